[hw/rtl/matrix_multiply_defines.svh]
// Assertion macros for the matrix multiplier RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define MM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix_multiply check failed");
// Next-cycle implication, disabled during reset
`define MM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix_multiply check failed");
`else
`define MM_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/mm_pkg.sv]
// Shared types, constants and helpers for the matrix multiplier.
// No dependencies; imported by the top level.
package mm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  // Field widths fixed by the stream format
  localparam int MODE_W    = 2;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 4;
  localparam int REG_IDX_W = 2;
  localparam int ACC_W     = 40;
  localparam int IN_HDR_W  = MODE_W + 2 * IDX_W;
  localparam int OUT_W     = ((ACC_W + 2 * IDX_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_A    = 2'd0,
    MODE_WR_B    = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  // Saturate a dimension register into 1..max_dim
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] max_dim);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > max_dim) begin
      r = max_dim;
    end
    return r;
  endfunction

endpackage

[hw/rtl/matrix_multiply.sv]
// Integer matrix multiplier C = A x B, top level.
// Depends on mm_pkg, mm_ram and matrix_multiply_defines.svh.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets rows_a (0),
//   inner_dim (1) and cols_b (2); cfg_ready is always high, values saturate
//   into 1..MAX_DIM. Write configuration only while the block is idle.
//   s_* stream: each transfer is a write of one A element, a write of one B
//   element, or a compute command. Writes outside the configured shape are
//   dropped. Writes are accepted back to back while the block is idle.
//   A compute command produces rows_a*cols_b transfers on m_* in row-major
//   order, tlast on the final entry. Each entry runs the shared multiplier
//   inner_dim times against the two element RAMs, each product passing
//   through RAM read, product register and accumulate. s_tready is low
//   for the whole compute.
//   m_* is registered: a stalled receiver holds the current entry and the
//   sequencer waits before loading the next one. After the final entry is
//   loaded the block takes new input while that entry still waits.
//   Reset clears the sequencer and sets all dimensions to 1; element RAMs
//   are not cleared and must be written before they are used.
module matrix_multiply #(
  parameter int  MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int  ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF,
  localparam int IN_W       = ((mm_pkg::IN_HDR_W + ELEM_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mm_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]      cfg_data,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_W-1:0]               s_tdata,  // mode, row, col, element_value
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mm_pkg::OUT_W-1:0]      m_tdata,  // product_value, out_row, out_col
  output logic                          m_tlast
);

  import mm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * ELEM_WIDTH;
  localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] rows_a, inner_dim, cols_b;
  logic [CFG_W-1:0] dim_m, dim_k, dim_n;

  logic [IDX_W-1:0] r_idx, c_idx, k_idx;
  logic             rd_valid, prod_valid;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;

  logic                  s_fire, out_free, entry_done, last_entry, last_k;
  mode_t                 in_mode;
  logic [IDX_W-1:0]      in_row, in_col;
  logic [ELEM_WIDTH-1:0] in_elem;
  logic                  a_we, b_we;
  logic [AW-1:0]         wr_addr, a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_W'(1);
      inner_dim <= CFG_W'(1);
      cols_b    <= CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign dim_m = clamp_dim(rows_a, DIM_MAX);
  assign dim_k = clamp_dim(inner_dim, DIM_MAX);
  assign dim_n = clamp_dim(cols_b, DIM_MAX);

  // Input decode
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign in_mode  = mode_t'(s_tdata[MODE_W-1:0]);
  assign in_row   = s_tdata[MODE_W +: IDX_W];
  assign in_col   = s_tdata[MODE_W + IDX_W +: IDX_W];
  assign in_elem  = s_tdata[IN_HDR_W +: ELEM_WIDTH];

  // Element writes, dropped when outside the configured shape
  assign a_we = s_fire && (in_mode == MODE_WR_A) &&
                (CFG_W'(in_row) < dim_m) && (CFG_W'(in_col) < dim_k);
  assign b_we = s_fire && (in_mode == MODE_WR_B) &&
                (CFG_W'(in_row) < dim_k) && (CFG_W'(in_col) < dim_n);
  assign wr_addr = AW'(in_row * MAX_DIM + in_col);

  // Read addresses for the current inner step
  assign a_raddr = AW'(r_idx * MAX_DIM + k_idx);
  assign b_raddr = AW'(k_idx * MAX_DIM + c_idx);

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (in_elem),
    .re    (state == ST_RUN),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (in_elem),
    .re    (state == ST_RUN),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Sequencer conditions
  assign last_k     = (CFG_W'(k_idx) == dim_k - CFG_W'(1));
  assign last_entry = (CFG_W'(r_idx) == dim_m - CFG_W'(1)) &&
                      (CFG_W'(c_idx) == dim_n - CFG_W'(1));
  assign out_free   = !m_tvalid || m_tready;
  assign entry_done = (state == ST_DRAIN) && !rd_valid && !prod_valid && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_fire && in_mode == MODE_COMPUTE) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (entry_done) begin
          state_next = last_entry ? ST_IDLE : ST_RUN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, indexes and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      r_idx      <= '0;
      c_idx      <= '0;
      k_idx      <= '0;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      state      <= state_next;
      rd_valid   <= (state == ST_RUN);
      prod_valid <= rd_valid;
      case (state)
        ST_IDLE: begin
          r_idx <= '0;
          c_idx <= '0;
          k_idx <= '0;
        end
        ST_RUN: begin
          if (!last_k) begin
            k_idx <= k_idx + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          // advance to the next entry in row-major order
          if (entry_done) begin
            k_idx <= '0;
            if (CFG_W'(c_idx) == dim_n - CFG_W'(1)) begin
              c_idx <= '0;
              r_idx <= r_idx + IDX_W'(1);
            end else begin
              c_idx <= c_idx + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Shared multiplier and accumulator
  always_ff @(posedge clk) begin
    prod <= $signed(a_rdata) * $signed(b_rdata);
    if (state != ST_RUN && state_next == ST_RUN) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (entry_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_done) begin
      m_tdata <= OUT_W'({c_idx, r_idx, acc});
      m_tlast <= last_entry;
    end
  end

  `include "matrix_multiply_defines.svh"

  `MM_ASSERT_SAME(a_ready_pipe_empty, clk, rst, s_tready, !rd_valid && !prod_valid)
  `MM_ASSERT_SAME(a_write_only_idle, clk, rst, a_we || b_we, state == ST_IDLE)
  `MM_ASSERT_NEXT(a_read_to_product, clk, rst, rd_valid, prod_valid)
  `MM_ASSERT_NEXT(a_last_returns_idle, clk, rst, entry_done && last_entry, state == ST_IDLE && m_tvalid && m_tlast)
  `MM_ASSERT_SAME(a_load_when_free, clk, rst, entry_done, !m_tvalid || m_tready)

endmodule

[hw/rtl/mm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the element stores of the matrix multiplier.
module mm_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
